### hw/rtl/c_subset_lexer_defines.svh
// Assertion macros for the c_subset_lexer checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef C_SUBSET_LEXER_DEFINES_SVH
`define C_SUBSET_LEXER_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define CSL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define CSL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/csl_pkg.sv
// Shared types and constants for the c_subset_lexer block.
// No dependencies; imported by every module of the block but csl_fifo.
`default_nettype none

package csl_pkg;

    localparam int POS_BITS_DEFAULT = 16;
    localparam int PREFIX_DEPTH     = 6;
    localparam int KW_COUNT         = 5;
    localparam int MID_DEPTH        = 2;
    localparam int OUT_DEPTH        = 2;

    localparam logic [62:0] NUM_MAX = '1;
    localparam logic [15:0] LEN_MAX = '1;

    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    typedef enum logic [2:0] {
        KIND_NUMBER = 3'd0,
        KIND_PUNCT  = 3'd1,
        KIND_KEYWORD = 3'd2,
        KIND_IDENT  = 3'd3,
        KIND_EOF    = 3'd4,
        KIND_ERROR  = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        KW_RETURN = 3'd0,
        KW_IF     = 3'd1,
        KW_ELSE   = 3'd2,
        KW_WHILE  = 3'd3,
        KW_FOR    = 3'd4
    } kw_t;

    // Keyword spellings, byte i of keyword k at [k][i]; unused tail is zero.
    localparam logic [7:0] KW_CHARS [KW_COUNT][PREFIX_DEPTH] = '{
        '{"r", "e", "t", "u", "r", "n"},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd6, 3'd2, 3'd4, 3'd5, 3'd3};

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } item_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [15:0] token_column;
        logic [15:0] token_length;
        logic [62:0] number_value;
        logic [7:0]  punct_first;
        logic [7:0]  punct_second;
        logic [2:0]  keyword_index;
        logic        last_of_run;
    } tok_t;

    // Classified byte handed from front to back.
    typedef struct packed {
        logic [7:0] byte_val;
        logic       eot;
        logic       is_space;
        logic       is_digit;
        logic       is_alpha;
        logic       is_name_more;
        logic       is_oper;
        logic       is_punct;
        logic       is_eq;
    } cls_t;

endpackage

`default_nettype wire

### hw/rtl/csl_fifo.sv
// Small flip-flop queue, power-of-two depth, used for the mid and result queues.
// No dependencies.
`default_nettype none

module csl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

    logic [DEPTH-1:0][WIDTH-1:0] mem_reg;
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

### hw/rtl/csl_front.sv
// Front stage: accepts source bytes and classifies them.
// Depends on csl_pkg.
`default_nettype none

module csl_front (
    input  wire logic           push,
    input  wire csl_pkg::item_t item,
    output logic                full,
    input  wire logic           mid_full,
    output logic                mid_push,
    output csl_pkg::cls_t       mid_data
);
    import csl_pkg::*;

    logic [7:0] b;
    logic digit, alpha;

    assign b     = item.text_byte;
    assign digit = (b >= 8'h30) && (b <= 8'h39);
    assign alpha = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));

    assign full     = mid_full;
    assign mid_push = push;

    always_comb
    begin
        mid_data              = '0;
        mid_data.byte_val     = b;
        mid_data.eot          = item.end_of_text;
        mid_data.is_space     = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
        mid_data.is_digit     = digit;
        mid_data.is_alpha     = alpha;
        mid_data.is_name_more = alpha || digit || (b == CH_UNDER);
        mid_data.is_oper      = (b == CH_EQ) || (b == CH_BANG) || (b == CH_LT)
                                || (b == CH_GT);
        mid_data.is_punct     = ((b >= 8'h21) && (b <= 8'h2F)) || ((b >= 8'h3A) && (b <= 8'h40))
                                || ((b >= 8'h5B) && (b <= 8'h60))
                                || ((b >= 8'h7B) && (b <= 8'h7E));
        mid_data.is_eq        = (b == CH_EQ);
    end

endmodule

`default_nettype wire

### hw/rtl/csl_back.sv
// Back stage: lexer state machine, builds up to two tokens per byte.
// Depends on csl_pkg.
`default_nettype none

module csl_back #(
    parameter int POSITION_BITS = csl_pkg::POS_BITS_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire csl_pkg::cls_t in_data,
    output logic               in_pop,
    output logic               out_push,
    output csl_pkg::tok_t      out_data,
    input  wire logic          out_full
);
    import csl_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_NAME,
        MODE_OPER,
        MODE_ERROR
    } mode_t;

    mode_t mode_reg, mode_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] tstart_reg, tstart_next;
    logic [POSITION_BITS-1:0] last_reg, last_next;
    logic [15:0] len_reg, len_next;
    logic [62:0] acc_reg, acc_next;
    logic [7:0]  pend_reg, pend_next;
    logic        phase_reg;
    logic [PREFIX_DEPTH-1:0][7:0] prefix_reg;

    logic        prefix_we;
    logic [2:0]  prefix_idx;
    logic [66:0] acc_x10;
    logic        kw_hit, kw_try;
    logic [2:0]  kw_idx;
    logic        has_pending, fl_valid, mn_valid, two, any_res;
    tok_t        fl_tok, mn_tok, first_tok, second_tok;
    logic [15:0] len_inc;

    assign len_inc = (len_reg == LEN_MAX) ? len_reg : len_reg + 16'd1;
    assign acc_x10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                     + 67'(in_data.byte_val[3:0]);

    // Keyword lookup on the stored name prefix
    always_comb
    begin
        kw_hit = 1'b0;
        kw_idx = '0;
        kw_try = 1'b0;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            kw_try = (len_reg == 16'(KW_LEN[k]));
            for (int i = 0; i < PREFIX_DEPTH; i++)
            begin
                if ((3'(i) < KW_LEN[k]) && (prefix_reg[i] != KW_CHARS[k][i]))
                    kw_try = 1'b0;
            end
            if (kw_try && !kw_hit)
            begin
                kw_hit = 1'b1;
                kw_idx = 3'(k);
            end
        end
    end

    // Token that a flush of the pending state produces
    always_comb
    begin
        fl_tok              = '0;
        fl_tok.token_column = 16'(tstart_reg);
        has_pending         = 1'b0;
        unique case (mode_reg)
            MODE_NUMBER:
            begin
                has_pending         = 1'b1;
                fl_tok.token_kind   = KIND_NUMBER;
                fl_tok.token_length = len_reg;
                fl_tok.number_value = acc_reg;
            end
            MODE_NAME:
            begin
                has_pending          = 1'b1;
                fl_tok.token_kind    = kw_hit ? KIND_KEYWORD : KIND_IDENT;
                fl_tok.token_length  = len_reg;
                fl_tok.keyword_index = kw_hit ? kw_idx : 3'(KW_RETURN);
            end
            MODE_OPER:
            begin
                has_pending         = 1'b1;
                fl_tok.token_kind   = KIND_PUNCT;
                fl_tok.token_length = 16'd1;
                fl_tok.punct_first  = pend_reg;
            end
            MODE_IDLE, MODE_ERROR:
                fl_tok = '0;
            default:
                fl_tok = '0;
        endcase
    end

    // Next state and the result of this byte
    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        tstart_next = tstart_reg;
        last_next   = last_reg;
        len_next    = len_reg;
        acc_next    = acc_reg;
        pend_next   = pend_reg;
        prefix_we   = 1'b0;
        prefix_idx  = len_reg[2:0];
        fl_valid    = 1'b0;
        mn_valid    = 1'b0;
        mn_tok      = '0;

        if (in_data.eot)
        begin
            fl_valid            = has_pending;
            mn_valid            = 1'b1;
            mn_tok.token_kind   = KIND_EOF;
            mn_tok.token_column = 16'(last_reg);
            mode_next           = MODE_IDLE;
            pos_next            = '0;
            tstart_next         = '0;
            last_next           = '0;
            len_next            = '0;
            acc_next            = '0;
            pend_next           = '0;
        end
        else if (mode_reg != MODE_ERROR)
        begin
            pos_next = pos_reg + 1'b1;
            if ((mode_reg == MODE_NUMBER) && in_data.is_digit)
            begin
                acc_next = (|acc_x10[66:63]) ? NUM_MAX : acc_x10[62:0];
                len_next = len_inc;
            end
            else if ((mode_reg == MODE_NAME) && in_data.is_name_more)
            begin
                prefix_we = (len_reg < 16'(PREFIX_DEPTH));
                len_next  = len_inc;
            end
            else if ((mode_reg == MODE_OPER) && in_data.is_eq)
            begin
                mn_valid            = 1'b1;
                mn_tok.token_kind   = KIND_PUNCT;
                mn_tok.token_column = 16'(tstart_reg);
                mn_tok.token_length = 16'd2;
                mn_tok.punct_first  = pend_reg;
                mn_tok.punct_second = CH_EQ;
                mode_next           = MODE_IDLE;
            end
            else
            begin
                fl_valid  = has_pending;
                mode_next = MODE_IDLE;
                if (!in_data.is_space)
                begin
                    tstart_next = pos_reg;
                    last_next   = pos_reg;
                    priority if (in_data.is_digit)
                    begin
                        mode_next = MODE_NUMBER;
                        acc_next  = 63'(in_data.byte_val[3:0]);
                        len_next  = 16'd1;
                    end
                    else if (in_data.is_oper)
                    begin
                        mode_next = MODE_OPER;
                        pend_next = in_data.byte_val;
                    end
                    else if (in_data.is_punct)
                    begin
                        mn_valid            = 1'b1;
                        mn_tok.token_kind   = KIND_PUNCT;
                        mn_tok.token_column = 16'(pos_reg);
                        mn_tok.token_length = 16'd1;
                        mn_tok.punct_first  = in_data.byte_val;
                    end
                    else if (in_data.is_alpha)
                    begin
                        mode_next  = MODE_NAME;
                        prefix_we  = 1'b1;
                        prefix_idx = '0;
                        len_next   = 16'd1;
                    end
                    else
                    begin
                        mn_valid            = 1'b1;
                        mn_tok.token_kind   = KIND_ERROR;
                        mn_tok.token_column = 16'(pos_reg);
                        mn_tok.punct_first  = in_data.byte_val;
                        mode_next           = MODE_ERROR;
                    end
                end
            end
        end
    end

    // Two results leave one after the other; state commits with the last one.
    assign two     = fl_valid && mn_valid;
    assign any_res = fl_valid || mn_valid;

    always_comb
    begin
        first_tok              = fl_valid ? fl_tok : mn_tok;
        first_tok.last_of_run  = !two;
        second_tok             = mn_tok;
        second_tok.last_of_run = 1'b1;
    end

    assign out_data = (two && phase_reg) ? second_tok : first_tok;
    assign out_push = in_valid && any_res && !out_full;
    assign in_pop   = in_valid && (!any_res || (!out_full && (!two || phase_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            tstart_reg <= '0;
            last_reg   <= '0;
            len_reg    <= '0;
            acc_reg    <= '0;
            pend_reg   <= '0;
            phase_reg  <= 1'b0;
        end
        else
        begin
            if (in_valid && two && !out_full)
                phase_reg <= !phase_reg;
            if (in_pop)
            begin
                mode_reg   <= mode_next;
                pos_reg    <= pos_next;
                tstart_reg <= tstart_next;
                last_reg   <= last_next;
                len_reg    <= len_next;
                acc_reg    <= acc_next;
                pend_reg   <= pend_next;
            end
        end
    end

    // Name prefix holds data only; no reset
    always_ff @(posedge clk)
    begin
        if (in_pop && prefix_we)
            prefix_reg[prefix_idx] <= in_data.byte_val;
    end

endmodule

`default_nettype wire

### hw/rtl/c_subset_lexer.sv
// A byte accepted into the middle queue has its tokens registered in the
// result queue. Throughput: one byte per cycle while the result queue has
// room; a byte that both ends a token and makes one (or an end marker after
// a pending token) holds the back stage while it writes both tokens in turn.
// Reset: rst_n asynchronous, active low; clears both queues and the lexer
// state at once, no clearing pass. Name prefix bytes are not reset.
`default_nettype none

module c_subset_lexer #(
    parameter int POSITION_BITS = csl_pkg::POS_BITS_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire csl_pkg::item_t item,
    output logic                full,
    output logic                empty,
    input  wire logic           pop,
    output csl_pkg::tok_t       result
);
    import csl_pkg::*;

    // Front side: accept and classify, then queue the classified byte.
    logic mid_full, mid_push, mid_empty, mid_pop;
    cls_t mid_wdata, mid_rdata;

    // Back side: lexer state machine feeding the result queue.
    logic out_full, out_push;
    tok_t out_wdata;

    csl_front u_front (
        .push     (push),
        .item     (item),
        .full     (full),
        .mid_full (mid_full),
        .mid_push (mid_push),
        .mid_data (mid_wdata)
    );

    // Short queue that lets the front keep taking bytes while the back
    // is still writing out the two tokens of a byte.
    csl_fifo #(
        .WIDTH ($bits(cls_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wdata),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    csl_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!mid_empty),
        .in_data  (mid_rdata),
        .in_pop   (mid_pop),
        .out_push (out_push),
        .out_data (out_wdata),
        .out_full (out_full)
    );

    // Result queue: registered tokens, oldest on the result ports.
    csl_fifo #(
        .WIDTH ($bits(tok_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_wdata),
        .full  (out_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

`default_nettype wire

### hw/rtl/csl_checker.sv
// Port-level checks on c_subset_lexer, attached by bind.
// Depends on csl_pkg and c_subset_lexer_defines.svh.
`default_nettype none
`include "c_subset_lexer_defines.svh"

module csl_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           push,
    input wire csl_pkg::item_t item,
    input wire logic           full,
    input wire logic           empty,
    input wire logic           pop,
    input wire csl_pkg::tok_t  result
);
    import csl_pkg::*;

    // waiting token must hold until popped
    `CSL_ASSERT_NXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(result), "token changed before pop")

    // EOF always closes its request and carries no length
    `CSL_ASSERT_IMP(a_eof, clk, rst_n, !empty && (result.token_kind == KIND_EOF), result.last_of_run && (result.token_length == 16'd0), "bad EOF token")

    // an error token is the last of its request
    `CSL_ASSERT_IMP(a_err, clk, rst_n, !empty && (result.token_kind == KIND_ERROR), result.last_of_run && (result.token_length == 16'd0), "bad error token")

    // only numbers carry a value
    `CSL_ASSERT_IMP(a_val, clk, rst_n, !empty && (result.token_kind != KIND_NUMBER), result.number_value == 63'd0, "value on non-number")

    // second operator byte only on two-byte punctuators
    `CSL_ASSERT_IMP(a_pair, clk, rst_n, !empty && (result.punct_second != 8'd0), (result.token_kind == KIND_PUNCT) && (result.token_length == 16'd2) && (result.punct_second == CH_EQ), "bad operator pair")

endmodule

bind c_subset_lexer csl_checker u_csl_checker (.*);

`default_nettype wire

### test/tb_top.sv
// Self-checking bench for c_subset_lexer: byte and end-marker requests in,
// tokens out, every token compared with an in-bench lexer model.
// Depends on csl_pkg and the c_subset_lexer RTL; nothing else.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import csl_pkg::*;

    // No request moves in either direction for this many cycles: hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Idle cycles after the last expected token has been popped.
    localparam int DRAIN_TAIL = 8;
    // Well past the six stored name bytes.
    localparam int LONG_NAME_LEN = 40;

    typedef enum logic [2:0] {
        LM_IDLE,
        LM_NUMBER,
        LM_NAME,
        LM_OPER,
        LM_ERROR
    } lex_mode_e;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  push = 1'b0;
    item_t item = '0;
    logic  full;
    logic  empty;
    logic  pop = 1'b0;
    tok_t  result;

    c_subset_lexer dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .item(item),
        .full(full),
        .empty(empty),
        .pop(pop),
        .result(result)
    );

    // ---------------------------------------------------------------------
    // Lexer model state, mirrors what the block must hold between bytes.
    // ---------------------------------------------------------------------
    lex_mode_e   lex_mode = LM_IDLE;
    logic [15:0] next_column = '0;      // column of the next byte
    logic [15:0] word_start = '0;       // column where the open token began
    logic [15:0] word_len = '0;         // saturating byte count of it
    logic [62:0] number_acc = '0;       // saturating decimal value
    logic [7:0]  held_op = '0;          // = ! < > waiting for a second '='
    logic [7:0]  word_head [6];         // first six bytes of a name
    logic [15:0] last_word_start = '0;  // column that EOF repeats

    string keyword_spelling [5] = '{"return", "if", "else", "while", "for"};
    kw_t   keyword_code [5] = '{KW_RETURN, KW_IF, KW_ELSE, KW_WHILE, KW_FOR};
    logic [7:0] blank_bytes [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    logic [7:0] op_lead [4] = '{CH_EQ, CH_BANG, CH_LT, CH_GT};

    tok_t expected_tokens [$];

    int mismatch_count = 0;
    int tokens_checked = 0;
    int bytes_lexed = 0;        // bytes that reached the lexer (not ignored)
    int eot_count = 0;
    int quiet_cycles = 0;
    int pop_hold = 0;
    bit sender_idle = 1'b0;
    bit receiver_idle = 1'b0;

    // ---------------------------------------------------------------------
    // Clock and reset: reset held low at the start, released once.
    // ---------------------------------------------------------------------
    initial
    begin
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // Byte classes
    // ---------------------------------------------------------------------
    function automatic bit is_blank(logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic bit is_dec(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_letter(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit is_symbol(logic [7:0] b);
        return (b >= 8'h21 && b <= 8'h2F) || (b >= 8'h3A && b <= 8'h40) ||
               (b >= 8'h5B && b <= 8'h60) || (b >= 8'h7B && b <= 8'h7E);
    endfunction

    // r in 0..62: letters, digits, underscore
    function automatic logic [7:0] name_char(int r);
        if (r < 26)
            return 8'("a" + r);
        else if (r < 52)
            return 8'("A" + r - 26);
        else if (r < 62)
            return 8'("0" + r - 52);
        return CH_UNDER;
    endfunction

    // ---------------------------------------------------------------------
    // Lexer model
    // ---------------------------------------------------------------------
    function automatic void push_token(kind_t kind, logic [15:0] col, logic [15:0] len,
                                       logic [62:0] val, logic [7:0] first,
                                       logic [7:0] second, logic [2:0] kw);
        tok_t t;
        t.token_kind    = kind;
        t.token_column  = col;
        t.token_length  = len;
        t.number_value  = val;
        t.punct_first   = first;
        t.punct_second  = second;
        t.keyword_index = kw;
        t.last_of_run   = 1'b0;
        expected_tokens.push_back(t);
    endfunction

    // Keyword only on an exact spelling; names over six bytes never match.
    function automatic void close_word();
        int k;
        int i;
        bit hit;
        for (k = 0; k < 5; k++)
        begin
            if (word_len == keyword_spelling[k].len())
            begin
                hit = 1'b1;
                for (i = 0; i < keyword_spelling[k].len(); i++)
                    if (word_head[i] != keyword_spelling[k][i])
                        hit = 1'b0;
                if (hit)
                begin
                    push_token(KIND_KEYWORD, word_start, word_len, '0, 8'h00, 8'h00,
                               keyword_code[k]);
                    return;
                end
            end
        end
        push_token(KIND_IDENT, word_start, word_len, '0, 8'h00, 8'h00, 3'd0);
    endfunction

    function automatic void close_pending();
        case (lex_mode)
            LM_NUMBER: push_token(KIND_NUMBER, word_start, word_len, number_acc,
                                  8'h00, 8'h00, 3'd0);
            LM_NAME:   close_word();
            LM_OPER:   push_token(KIND_PUNCT, word_start, 16'd1, '0, held_op, 8'h00, 3'd0);
            default:   ;
        endcase
        if (lex_mode != LM_ERROR)
            lex_mode = LM_IDLE;
    endfunction

    function automatic void lex_item(item_t it);
        int          queued_at_entry;
        logic [7:0]  b;
        logic [15:0] here;
        logic [63:0] digit;
        bit          taken;
        tok_t        tail;
        queued_at_entry = expected_tokens.size();
        b = it.text_byte;
        taken = 1'b0;
        if (it.end_of_text)
        begin
            // flush, report EOF, then everything back to its reset value
            close_pending();
            push_token(KIND_EOF, last_word_start, '0, '0, 8'h00, 8'h00, 3'd0);
            lex_mode = LM_IDLE;
            next_column = '0;
            word_start = '0;
            word_len = '0;
            number_acc = '0;
            held_op = '0;
            last_word_start = '0;
        end
        else if (lex_mode != LM_ERROR)
        begin
            here = next_column;
            next_column = next_column + 16'd1;
            digit = {56'd0, b} - 64'd48;
            case (lex_mode)
                LM_NUMBER:
                    if (is_dec(b))
                    begin
                        if ({1'b0, number_acc} > ({1'b0, NUM_MAX} - digit) / 64'd10)
                            number_acc = NUM_MAX;
                        else
                            number_acc = number_acc * 63'd10 + digit[62:0];
                        if (word_len != LEN_MAX)
                            word_len++;
                        taken = 1'b1;
                    end
                    else
                        close_pending();
                LM_NAME:
                    if (is_letter(b) || is_dec(b) || b == CH_UNDER)
                    begin
                        if (word_len < 16'd6)
                            word_head[word_len] = b;
                        if (word_len != LEN_MAX)
                            word_len++;
                        taken = 1'b1;
                    end
                    else
                        close_pending();
                LM_OPER:
                    if (b == CH_EQ)
                    begin
                        push_token(KIND_PUNCT, word_start, 16'd2, '0, held_op, CH_EQ, 3'd0);
                        lex_mode = LM_IDLE;
                        taken = 1'b1;
                    end
                    else
                        close_pending();
                default: ;
            endcase
            if (!taken && !is_blank(b))
            begin
                word_start = here;
                last_word_start = here;
                if (is_dec(b))
                begin
                    lex_mode = LM_NUMBER;
                    number_acc = {55'd0, b - 8'h30};
                    word_len = 16'd1;
                end
                else if (b == CH_EQ || b == CH_BANG || b == CH_LT || b == CH_GT)
                begin
                    lex_mode = LM_OPER;
                    held_op = b;
                end
                else if (is_symbol(b))
                    push_token(KIND_PUNCT, here, 16'd1, '0, b, 8'h00, 3'd0);
                else if (is_letter(b))
                begin
                    lex_mode = LM_NAME;
                    word_head[0] = b;
                    word_len = 16'd1;
                end
                else
                begin
                    push_token(KIND_ERROR, here, '0, '0, b, 8'h00, 3'd0);
                    lex_mode = LM_ERROR;
                end
            end
        end
        if (expected_tokens.size() > queued_at_entry)
        begin
            tail = expected_tokens.pop_back();
            tail.last_of_run = 1'b1;
            expected_tokens.push_back(tail);
        end
    endfunction

    // ---------------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------------
    function automatic string tok_text(tok_t t);
        return $sformatf("kind=%0d col=%0d len=%0d val=%0d p1=%02h p2=%02h kw=%0d last=%0b",
                         t.token_kind, t.token_column, t.token_length, t.number_value,
                         t.punct_first, t.punct_second, t.keyword_index, t.last_of_run);
    endfunction

    task automatic report_mismatch(input string why, input tok_t want, input tok_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t ERROR %s\n  expected %s\n  actual   %s", $realtime, why,
                     tok_text(want), tok_text(got));
    endtask

    // Sampled at the rising edge: outputs still hold their pre-edge values
    // here. Result requests are checked before the input request of the same
    // edge is fed to the model, so ordering never matters.
    always @(posedge clk)
    begin : monitor
        tok_t  want;
        string bad;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_tokens.size() == 0)
                    report_mismatch("token with none expected", '0, result);
                else
                begin
                    want = expected_tokens.pop_front();
                    bad = "";
                    if (result.token_kind !== want.token_kind)       bad = {bad, " kind"};
                    if (result.token_column !== want.token_column)   bad = {bad, " column"};
                    if (result.token_length !== want.token_length)   bad = {bad, " length"};
                    if (result.number_value !== want.number_value)   bad = {bad, " value"};
                    if (result.punct_first !== want.punct_first)     bad = {bad, " first"};
                    if (result.punct_second !== want.punct_second)   bad = {bad, " second"};
                    if (result.keyword_index !== want.keyword_index) bad = {bad, " keyword"};
                    if (result.last_of_run !== want.last_of_run)     bad = {bad, " last"};
                    if (bad != "")
                        report_mismatch({"wrong", bad}, want, result);
                    tokens_checked++;
                end
            end
            if (push && !full)
            begin
                if (item.end_of_text)
                    eot_count++;
                else if (lex_mode != LM_ERROR)
                    bytes_lexed++;
                lex_item(item);
            end
            quiet_cycles = ((pop && !empty) || (push && !full)) ? 0 : quiet_cycles + 1;
        end
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("%0t watchdog: no request moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Result side: pop held low in random bursts while receiver_idle is set.
    // ---------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (pop_hold == 0 && receiver_idle && $urandom_range(0, 9) == 0)
            pop_hold = $urandom_range(1, 12);
        if (pop_hold != 0)
        begin
            pop <= 1'b0;
            pop_hold--;
        end
        else
            pop <= 1'b1;
    end

    // ---------------------------------------------------------------------
    // Input side. Each call starts and ends at a falling edge; push is only
    // assigned once per edge, so a back-to-back request keeps push high.
    // ---------------------------------------------------------------------
    task automatic send_item(input logic [7:0] b, input bit eot);
        item_t next;
        int    gap;
        if (sender_idle && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        next.text_byte = b;
        next.end_of_text = eot;
        push <= 1'b1;
        item <= next;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    // The byte under an end marker is random: the block must ignore it.
    task automatic send_eot();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Sender stops until every expected token has been popped.
    task automatic wait_drained();
        push <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
        @(negedge clk);
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // All five keywords, a seven-letter name that starts like one, and EOF
    // that flushes a pending name.
    task automatic test_keywords();
        send_text("return if\telse\nwhile for returns");
        send_eot();
        wait_drained();
    endtask

    // Underscore as punctuator, ==, single < and ! flushed by the next
    // operator byte, >=, zero, a value past 2^63-1, and EOF with byte FF.
    task automatic test_operators_and_numbers();
        send_text("_x_9==0<!>= 9223372036854775807 99999999999999999999");
        send_item(8'hFF, 1'b1);
        wait_drained();
    endtask

    // Token then error on the same byte, ignored bytes after an error,
    // NUL, DEL, a pending operator ahead of an error, and an empty text.
    task automatic test_bad_bytes();
        send_text("ab");
        send_item(8'h80, 1'b0);
        send_text("12");
        send_eot();
        send_item(8'h00, 1'b0);
        send_eot();
        send_text("=");
        send_item(8'hFF, 1'b0);
        send_eot();
        send_item(8'h7F, 1'b0);
        send_eot();
        send_eot();
        wait_drained();
    endtask

    // One name far longer than the six stored bytes: an identifier with its
    // full length, and the token after it at the right column.
    task automatic test_long_token();
        int i;
        send_item(name_char($urandom_range(0, 51)), 1'b0);
        for (i = 1; i < LONG_NAME_LEN; i++)
            send_item(name_char($urandom_range(0, 62)), 1'b0);
        send_text(" 7");
        send_eot();
        wait_drained();
    endtask

    // Mostly well-formed tokens with random content and random spacing,
    // some noise bytes, invalid bytes and end markers mixed in.
    task automatic test_random_text(input int target);
        int         start;
        int         pick;
        int         n;
        int         i;
        logic [7:0] b;
        start = bytes_lexed;
        while (bytes_lexed - start < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    send_text(keyword_spelling[$urandom_range(0, 4)]);
                    if ($urandom_range(0, 4) == 0)
                        send_item(name_char($urandom_range(0, 62)), 1'b0);
                end
                else
                begin
                    n = $urandom_range(1, 9);
                    send_item(name_char($urandom_range(0, 51)), 1'b0);
                    for (i = 1; i < n; i++)
                        send_item(name_char($urandom_range(0, 62)), 1'b0);
                end
            end
            else if (pick < 45)
            begin
                // short numbers mostly; some long enough to saturate
                n = ($urandom_range(0, 6) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 6);
                if ($urandom_range(0, 1) == 0 && n > 17)
                    for (i = 0; i < n; i++)
                        send_item("9", 1'b0);
                else
                    for (i = 0; i < n; i++)
                        send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
            end
            else if (pick < 65)
            begin
                send_item(op_lead[$urandom_range(0, 3)], 1'b0);
                if ($urandom_range(0, 4) < 3)
                    send_item(CH_EQ, 1'b0);
            end
            else if (pick < 80)
            begin
                do
                    b = 8'($urandom_range(8'h21, 8'h7E));
                while (!is_symbol(b));
                send_item(b, 1'b0);
            end
            else if (pick < 88)
            begin
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++)
                    send_item(blank_bytes[$urandom_range(0, 5)], 1'b0);
            end
            else if (pick < 91)
            begin
                // non-ASCII, NUL or a control byte that is not whitespace
                do
                    b = 8'($urandom_range(0, 255));
                while (is_blank(b) || (b >= 8'h20 && b <= 8'h7E));
                send_item(b, 1'b0);
            end
            else if (pick < 95)
                send_item(8'($urandom_range(0, 255)), 1'b0);
            else
                send_eot();

            // tokens run together about two times in five
            if (pick < 80 && $urandom_range(0, 4) < 3)
                send_item(blank_bytes[$urandom_range(0, 5)], 1'b0);
            // after an error most texts end soon, so few bytes go to waste
            if (lex_mode == LM_ERROR && $urandom_range(0, 9) < 7)
                send_eot();
        end
        send_eot();
        wait_drained();
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial
    begin : run
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        sender_idle = 1'b1;
        receiver_idle = 1'b1;
        test_keywords();
        test_operators_and_numbers();
        test_bad_bytes();
        test_long_token();
        test_random_text(600);

        // last stretch at full rate on both sides
        sender_idle = 1'b0;
        receiver_idle = 1'b0;
        test_random_text(200);

        $display("Run covered %0d lexed bytes, %0d end markers and %0d tokens,",
                 bytes_lexed, eot_count, tokens_checked);
        $display("with keywords, operator pairs, saturated values, bad bytes and stall bursts.");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
